>>> sv/ucd_pkg.sv
`timescale 1ns / 1ps

package ucd_pkg;

    // Sizing
    localparam int BUFFER_BYTES   = 256;
    localparam int EXPONENT_LIMIT = 38;
    localparam int CountW         = $clog2(BUFFER_BYTES);

    // Magnitude limits used by the scaling loop and the int16 clamp
    localparam logic [31:0] MagCapIn  = 32'd32768;
    localparam logic [16:0] MagCap    = 17'd32769;
    localparam logic [16:0] MagNegMax = 17'd32768;
    localparam logic [16:0] MagPosMax = 17'd32767;

    // Reciprocal of ten, exact for any 32-bit dividend with a shift of 35
    localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;

    // Register indexes
    localparam logic [1:0] REG_TERMINATOR = 2'd0;
    localparam logic [1:0] REG_DELIMITER  = 2'd1;
    localparam logic [1:0] REG_HEADER     = 2'd2;

    // Register reset values
    localparam logic [7:0] TERM_RESET   = 8'h21;
    localparam logic [7:0] DELIM_RESET  = 8'h3D;
    localparam logic [7:0] HEADER_RESET = 8'h50;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;

    // Result codes
    typedef enum logic [2:0] {
        CMD_UNKNOWN  = 3'd0,
        CMD_RUN      = 3'd1,
        CMD_SPEED    = 3'd2,
        CMD_NO_DELIM = 3'd3,
        CMD_OVERFLOW = 3'd4
    } t_cmd_code;

    // Operations of the shared scaling unit
    typedef enum logic [1:0] {
        SOP_HOLD  = 2'd0,
        SOP_LOAD  = 2'd1,
        SOP_MUL10 = 2'd2,
        SOP_DIV10 = 2'd3
    } t_scale_op;

    // Frame summary handed from the parser to the sequencer
    typedef struct packed {
        logic        overflow;
        logic        delim_seen;
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic        negative;
        logic [31:0] mantissa;
        logic [7:0]  frac_digits;
        logic [7:0]  exp_value;
        logic        exp_negative;
        logic [7:0]  dropped;
    } t_frame;

endpackage

>>> sv/uart_text_command_decoder.sv
`timescale 1ns / 1ps
// Order: a data beat is absorbed into the parser registers; a terminator beat goes to the
//   emit state, first through the scale state for valued codes within the exponent limit,
//   where the shared x10 / divide-by-10 unit makes at most 5 multiply or 10 divide steps,
//   one per cycle. Throughput: one data beat per cycle; the input stalls from a terminator
//   until its result is loaded into the output register.
// Reset: synchronous, active low; registers return to '!', '=', 'P', frame cleared.
module uart_text_command_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_command_code,
    output logic        o_run_on,
    output logic [15:0] o_speed_cmd,
    output logic        o_value_saturated
);
    import ucd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCALE = 2'd1,
        ST_EMIT  = 2'd2
    } t_state;

    // Configuration registers
    logic [7:0] r_term, r_delim, r_header;

    // Sequencer
    t_state      r_state;
    t_cmd_code   r_code;
    logic        r_neg;
    logic        r_up;
    logic [8:0]  r_cnt;
    logic [16:0] r_mag;
    logic        r_out_valid;
    logic [2:0]  r_out_code;
    logic        r_out_run;
    logic [15:0] r_out_speed;
    logic        r_out_sat;

    t_frame      frame;
    t_scale_op   sop;
    logic [31:0] uval;
    logic        in_acc;
    logic        is_term;
    logic        hdr_ok;
    t_cmd_code   term_code;
    logic [9:0]  scale;
    logic [8:0]  scale_abs;
    logic        scale_done;
    logic        out_free;

    logic        emit_sat;
    logic        emit_run;
    logic [15:0] emit_speed;
    logic [16:0] mag_neg;

    assign in_acc     = i_in_valid && o_in_ready;
    assign is_term    = (i_rx_byte == r_term);
    assign o_in_ready = (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term   <= TERM_RESET;
            r_delim  <= DELIM_RESET;
            r_header <= HEADER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TERMINATOR: r_term   <= i_cfg_data;
                REG_DELIMITER:  r_delim  <= i_cfg_data;
                REG_HEADER:     r_header <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ucd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (in_acc && !is_term),
        .i_clear      (in_acc && is_term),
        .i_byte       (i_rx_byte),
        .i_delim      (r_delim),
        .o_frame      (frame)
    );

    ucd_scale_unit u_scale (
        .i_clk      (i_clk),
        .i_op       (sop),
        .i_load_val (frame.mantissa),
        .o_val      (uval)
    );

    // Classify the frame at the terminator
    always_comb begin
        hdr_ok = (frame.first_char == r_header) &&
                 (frame.second_char == CH_ONE || frame.second_char == CH_TWO);
        if (frame.overflow)        term_code = CMD_OVERFLOW;
        else if (!frame.delim_seen) term_code = CMD_NO_DELIM;
        else if (hdr_ok)           term_code = (frame.second_char == CH_ONE) ? CMD_RUN
                                                                              : CMD_SPEED;
        else                       term_code = CMD_UNKNOWN;
    end

    // Decimal scale: +-exponent + dropped digits - fraction digits
    always_comb begin
        scale = (frame.exp_negative ? -{2'b00, frame.exp_value} : {2'b00, frame.exp_value})
              + {2'b00, frame.dropped} - {2'b00, frame.frac_digits};
        scale_abs = scale[9] ? 9'(-scale) : scale[8:0];
    end

    // Loop ends on count, on a zero value, or on overflow going up
    assign scale_done = (r_cnt == 9'd0) ||
                        (uval == 32'd0) ||
                        (r_up && (uval > MagCapIn));

    // Unit control
    always_comb begin
        sop = SOP_HOLD;
        if (r_state == ST_IDLE && in_acc && is_term) begin
            sop = SOP_LOAD;
        end else if (r_state == ST_SCALE && !scale_done) begin
            sop = r_up ? SOP_MUL10 : SOP_DIV10;
        end
    end

    // Clamp to int16 and form the result fields
    always_comb begin
        mag_neg    = 17'd0 - r_mag;
        emit_sat   = 1'b0;
        emit_run   = 1'b0;
        emit_speed = 16'd0;
        if (r_neg) begin
            if (r_mag > MagNegMax) begin
                emit_sat   = 1'b1;
                emit_speed = 16'h8000;
            end else begin
                emit_speed = mag_neg[15:0];
            end
        end else begin
            if (r_mag > MagPosMax) begin
                emit_sat   = 1'b1;
                emit_speed = MagPosMax[15:0];
            end else begin
                emit_speed = r_mag[15:0];
                emit_run   = (r_mag == 17'd1);
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_code      <= CMD_UNKNOWN;
            r_neg       <= 1'b0;
            r_up        <= 1'b0;
            r_cnt       <= '0;
            r_mag       <= '0;
        end else begin
            // the emit state reloads the output beat itself
            if (r_out_valid && i_out_ready && r_state != ST_EMIT) r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && is_term) begin
                        r_code <= term_code;
                        r_neg  <= frame.negative;
                        r_mag  <= '0;
                        r_up   <= !scale[9] && (scale != 10'd0);
                        r_cnt  <= scale_abs;
                        if (term_code != CMD_RUN && term_code != CMD_SPEED) begin
                            r_state <= ST_EMIT;
                        end else if (frame.exp_value > 8'(EXPONENT_LIMIT)) begin
                            r_mag   <= (frame.exp_negative || frame.mantissa == 32'd0)
                                       ? 17'd0 : MagCap;
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    if (scale_done) begin
                        r_mag   <= (uval > MagCapIn) ? MagCap : uval[16:0];
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt - 9'd1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_code  <= r_code;
                        r_out_run   <= (r_code == CMD_RUN) && emit_run;
                        r_out_speed <= (r_code == CMD_SPEED) ? emit_speed : 16'd0;
                        r_out_sat   <= (r_code == CMD_RUN || r_code == CMD_SPEED) && emit_sat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_command_code    = r_out_code;
    assign o_run_on          = r_out_run;
    assign o_speed_cmd       = r_out_speed;
    assign o_value_saturated = r_out_sat;

`ifndef SYNTHESIS
    // A terminator beat stalls the input on the next cycle
    a_term_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_term) |=> !o_in_ready)
        else $error("input not stalled after terminator");

    // run_on only on a run/stop result
    a_run_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_on) |-> (o_command_code == CMD_RUN))
        else $error("run_on set outside run/stop result");

    // speed only on a speed result
    a_speed_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speed_cmd != 16'd0) |-> (o_command_code == CMD_SPEED))
        else $error("speed command set outside speed result");

    // saturation flag only on valued results
    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_value_saturated) |->
        (o_command_code == CMD_RUN || o_command_code == CMD_SPEED))
        else $error("saturation flag on a result without value");
`endif

endmodule

>>> sv/ucd_parser.sv
`timescale 1ns / 1ps

module ucd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_valid,
    input  logic          i_clear,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_delim,
    output ucd_pkg::t_frame o_frame
);
    import ucd_pkg::*;

    typedef enum logic [2:0] {
        PH_WS    = 3'd0,
        PH_INT   = 3'd1,
        PH_FRAC  = 3'd2,
        PH_ESIGN = 3'd3,
        PH_EXP   = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    logic [CountW-1:0] r_count, n_count;
    logic [7:0]        r_first, n_first;
    logic [7:0]        r_second, n_second;
    logic              r_delim, n_delim;
    logic              r_ended, n_ended;
    t_phase            r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [31:0]       r_mant, n_mant;
    logic [7:0]        r_frac, n_frac;
    logic [7:0]        r_exp, n_exp;
    logic              r_eneg, n_eneg;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_drop, n_drop;

    t_phase      ph;
    logic        consumed;
    logic        is_ws;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] mant_next;
    logic [11:0] exp_next;

    // mantissa * 10 + d, and exponent * 10 + d
    assign digit     = i_byte[3:0];
    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_ws     = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign mant_next = {1'b0, r_mant, 3'b000} + {3'b000, r_mant, 1'b0} + {32'd0, digit};
    assign exp_next  = {1'b0, r_exp, 3'b000} + {3'b000, r_exp, 1'b0} + {8'd0, digit};

    // Per-beat frame and number parsing
    always_comb begin
        n_count  = r_count;
        n_first  = r_first;
        n_second = r_second;
        n_delim  = r_delim;
        n_ended  = r_ended;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_mant   = r_mant;
        n_frac   = r_frac;
        n_exp    = r_exp;
        n_eneg   = r_eneg;
        n_ovf    = r_ovf;
        n_drop   = r_drop;
        ph       = r_phase;
        consumed = 1'b0;

        if (i_clear) begin
            n_count  = '0;
            n_first  = '0;
            n_second = '0;
            n_delim  = 1'b0;
            n_ended  = 1'b0;
            n_phase  = PH_WS;
            n_neg    = 1'b0;
            n_mant   = '0;
            n_frac   = '0;
            n_exp    = '0;
            n_eneg   = 1'b0;
            n_ovf    = 1'b0;
            n_drop   = '0;
        end else if (i_byte_valid) begin
            if (r_count >= CountW'(BUFFER_BYTES - 1)) begin
                n_ovf = 1'b1;
            end else begin
                if (!r_ended) begin
                    if (i_byte == CH_NUL) begin
                        n_ended = 1'b1;
                    end else begin
                        if (r_count == CountW'(0)) n_first = i_byte;
                        else if (r_count == CountW'(1)) n_second = i_byte;

                        if (!r_delim) begin
                            if (i_byte == i_delim) n_delim = 1'b1;
                        end else begin
                            // leading whitespace and sign
                            if (ph == PH_WS) begin
                                if (is_ws) begin
                                    consumed = 1'b1;
                                end else begin
                                    ph = PH_INT;
                                    if (i_byte == CH_MINUS) begin
                                        n_neg    = 1'b1;
                                        consumed = 1'b1;
                                    end else if (i_byte == CH_PLUS) begin
                                        consumed = 1'b1;
                                    end
                                end
                            end
                            // exponent sign
                            if (!consumed && ph == PH_ESIGN) begin
                                ph = PH_EXP;
                                if (i_byte == CH_MINUS) begin
                                    n_eneg   = 1'b1;
                                    consumed = 1'b1;
                                end else if (i_byte == CH_PLUS) begin
                                    consumed = 1'b1;
                                end
                            end
                            // digits, point, exponent mark
                            if (!consumed && ph != PH_STOP) begin
                                if (is_digit) begin
                                    if (ph == PH_EXP) begin
                                        n_exp = (exp_next > 12'd255) ? 8'd255 : exp_next[7:0];
                                    end else if (mant_next[35:32] == 4'd0) begin
                                        n_mant = mant_next[31:0];
                                        if (ph == PH_FRAC && r_frac != 8'd255) begin
                                            n_frac = r_frac + 8'd1;
                                        end
                                    end else if (ph == PH_INT && r_drop != 8'd255) begin
                                        n_drop = r_drop + 8'd1;
                                    end
                                end else if (i_byte == CH_DOT && ph == PH_INT) begin
                                    ph = PH_FRAC;
                                end else if ((i_byte == CH_E_LO || i_byte == CH_E_UP) &&
                                             (ph == PH_INT || ph == PH_FRAC)) begin
                                    ph = PH_ESIGN;
                                end else begin
                                    ph = PH_STOP;
                                end
                            end
                            n_phase = ph;
                        end
                    end
                end
                n_count = r_count + CountW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_delim  <= 1'b0;
            r_ended  <= 1'b0;
            r_phase  <= PH_WS;
            r_neg    <= 1'b0;
            r_mant   <= '0;
            r_frac   <= '0;
            r_exp    <= '0;
            r_eneg   <= 1'b0;
            r_ovf    <= 1'b0;
            r_drop   <= '0;
        end else begin
            r_count  <= n_count;
            r_first  <= n_first;
            r_second <= n_second;
            r_delim  <= n_delim;
            r_ended  <= n_ended;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_mant   <= n_mant;
            r_frac   <= n_frac;
            r_exp    <= n_exp;
            r_eneg   <= n_eneg;
            r_ovf    <= n_ovf;
            r_drop   <= n_drop;
        end
    end

    assign o_frame.overflow     = r_ovf;
    assign o_frame.delim_seen   = r_delim;
    assign o_frame.first_char   = r_first;
    assign o_frame.second_char  = r_second;
    assign o_frame.negative     = r_neg;
    assign o_frame.mantissa     = r_mant;
    assign o_frame.frac_digits  = r_frac;
    assign o_frame.exp_value    = r_exp;
    assign o_frame.exp_negative = r_eneg;
    assign o_frame.dropped      = r_drop;

endmodule

>>> sv/ucd_scale_unit.sv
`timescale 1ns / 1ps

module ucd_scale_unit (
    input  logic                 i_clk,
    input  ucd_pkg::t_scale_op   i_op,
    input  logic [31:0]          i_load_val,
    output logic [31:0]          o_val
);
    import ucd_pkg::*;

    logic [31:0] r_val;
    logic [31:0] n_val;
    logic [63:0] div_prod;
    logic [31:0] mul_val;

    // x10 as shift-add; /10 as reciprocal multiply
    assign mul_val  = {r_val[28:0], 3'b000} + {r_val[30:0], 1'b0};
    assign div_prod = {32'd0, r_val} * {32'd0, Recip10};

    always_comb begin
        unique case (i_op)
            SOP_LOAD:  n_val = i_load_val;
            SOP_MUL10: n_val = mul_val;
            SOP_DIV10: n_val = {3'b000, div_prod[63:35]};
            default:   n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

>>> tb/sv/ucd_frame_checker.sv
`timescale 1ns / 1ps

// Watches the byte and result channels of the command decoder, keeps its own
// model of the framing and number parsing, and compares every result beat.
module ucd_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_command_code,
    input  logic        i_run_on,
    input  logic [15:0] i_speed_cmd,
    input  logic        i_value_saturated,
    output int          o_mismatch_count,
    output int          o_pending_count,
    output int          o_result_count
);
    import ucd_pkg::*;

    typedef enum logic [2:0] {
        NUM_WS    = 3'd0,
        NUM_INT   = 3'd1,
        NUM_FRAC  = 3'd2,
        NUM_ESIGN = 3'd3,
        NUM_EXP   = 3'd4,
        NUM_STOP  = 3'd5
    } t_num_phase;

    typedef struct packed {
        t_cmd_code   code;
        logic        run_on;
        logic [15:0] speed_cmd;
        logic        saturated;
    } t_cmd_result;

    // Register copies
    logic [7:0] term_c;
    logic [7:0] delim_c;
    logic [7:0] hdr_c;

    // Frame state
    logic [8:0]  frame_len;
    logic [7:0]  head0;
    logic [7:0]  head1;
    logic        saw_delim;
    logic        text_done;
    t_num_phase  phase;
    logic        neg;
    logic [31:0] mant;
    logic [7:0]  frac_cnt;
    logic [7:0]  exp_val;
    logic        exp_neg;
    logic        overflowed;
    logic [7:0]  dropped;

    t_cmd_result pending_cmds[$];

    function automatic void clear_frame();
        frame_len  = '0;
        head0      = '0;
        head1      = '0;
        saw_delim  = 1'b0;
        text_done  = 1'b0;
        phase      = NUM_WS;
        neg        = 1'b0;
        mant       = '0;
        frac_cnt   = '0;
        exp_val    = '0;
        exp_neg    = 1'b0;
        overflowed = 1'b0;
        dropped    = '0;
    endfunction

    // One character of the argument, after the delimiter
    function automatic void parse_char(logic [7:0] c);
        logic [31:0] d;
        int unsigned e;
        if (phase == NUM_WS) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
            phase = NUM_INT;
            if (c == CH_MINUS) begin
                neg = 1'b1;
                return;
            end
            if (c == CH_PLUS) return;
        end
        if (phase == NUM_ESIGN) begin
            phase = NUM_EXP;
            if (c == CH_MINUS) begin
                exp_neg = 1'b1;
                return;
            end
            if (c == CH_PLUS) return;
        end
        if (phase == NUM_STOP) return;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 32'(c - CH_ZERO);
            if (phase == NUM_EXP) begin
                e = exp_val * 10 + d;
                exp_val = (e > 255) ? 8'd255 : 8'(e);
            end else if (mant <= (32'hFFFF_FFFF - d) / 10) begin
                mant = mant * 10 + d;
                if (phase == NUM_FRAC && frac_cnt < 8'd255) frac_cnt++;
            end else if (phase == NUM_INT && dropped < 8'd255) begin
                dropped++;
            end
            return;
        end
        if (c == CH_DOT && phase == NUM_INT) begin
            phase = NUM_FRAC;
            return;
        end
        if ((c == CH_E_LO || c == CH_E_UP) && phase < NUM_ESIGN) begin
            phase = NUM_ESIGN;
            return;
        end
        phase = NUM_STOP;
    endfunction

    // Truncated magnitude of the argument, capped at 32769
    function automatic int unsigned magnitude();
        longint unsigned v;
        int scale;
        v = mant;
        if (v == 0) return 0;
        if (exp_val > EXPONENT_LIMIT) return exp_neg ? 0 : 32769;
        scale = (exp_neg ? -int'(exp_val) : int'(exp_val)) + int'(dropped) - int'(frac_cnt);
        for (int i = 0; i < scale; i++) begin
            v = v * 10;
            if (v > 32768) return 32769;
        end
        for (int i = 0; i < -scale && v != 0; i++) v = v / 10;
        return (v > 32768) ? 32769 : int'(v);
    endfunction

    // Result of the frame closed by a terminator
    function automatic t_cmd_result close_frame();
        t_cmd_result r;
        int unsigned m;
        r.code      = CMD_UNKNOWN;
        r.run_on    = 1'b0;
        r.speed_cmd = '0;
        r.saturated = 1'b0;
        if (overflowed) begin
            r.code = CMD_OVERFLOW;
        end else if (!saw_delim) begin
            r.code = CMD_NO_DELIM;
        end else if (head0 == hdr_c && (head1 == CH_ONE || head1 == CH_TWO)) begin
            m = magnitude();
            if (neg) begin
                if (m > 32768) begin
                    m = 32768;
                    r.saturated = 1'b1;
                end
                r.speed_cmd = ~m[15:0] + 16'd1;
            end else begin
                if (m > 32767) begin
                    m = 32767;
                    r.saturated = 1'b1;
                end
                r.speed_cmd = m[15:0];
                r.run_on    = (m == 1);
            end
            if (head1 == CH_ONE) begin
                r.code      = CMD_RUN;
                r.speed_cmd = '0;
            end else begin
                r.code   = CMD_SPEED;
                r.run_on = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic void take_byte(logic [7:0] c);
        if (c == term_c) begin
            pending_cmds.push_back(close_frame());
            clear_frame();
            return;
        end
        if (frame_len >= BUFFER_BYTES - 1) begin
            overflowed = 1'b1;
            return;
        end
        if (!text_done) begin
            if (c == CH_NUL) begin
                text_done = 1'b1;
            end else begin
                if (frame_len == 0) head0 = c;
                else if (frame_len == 1) head1 = c;
                if (saw_delim) parse_char(c);
                else if (c == delim_c) saw_delim = 1'b1;
            end
        end
        frame_len++;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            o_mismatch_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Result beats are checked before the byte beat of the same edge
    always @(posedge i_clk) begin
        t_cmd_result want;
        if (!i_rst_n) begin
            term_c  = TERM_RESET;
            delim_c = DELIM_RESET;
            hdr_c   = HEADER_RESET;
            clear_frame();
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TERMINATOR: term_c  = i_cfg_data;
                    REG_DELIMITER:  delim_c = i_cfg_data;
                    REG_HEADER:     hdr_c   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (pending_cmds.size() == 0) begin
                    o_mismatch_count++;
                    $error("result beat with no command pending (code %0d)", i_command_code);
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("command_code", want.code, i_command_code);
                    check_field("run_on", want.run_on, i_run_on);
                    check_field("speed_cmd", int'($signed(want.speed_cmd)),
                                int'($signed(i_speed_cmd)));
                    check_field("value_saturated", want.saturated, i_value_saturated);
                end
            end
            if (i_in_valid && i_in_ready) take_byte(i_rx_byte);
        end
        o_pending_count = pending_cmds.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the command decoder; checking lives in the checker.
module tb;
    import ucd_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int CALM_FROM    = 1500;
    localparam int CALM_TO      = 2300;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  command_code;
    logic        run_on;
    logic [15:0] speed_cmd;
    logic        value_saturated;

    int mismatch_count;
    int pending_count;
    int result_count;
    int cyc = 0;
    int beats_sent = 0;
    int settings_run = 0;
    logic calm;

    // Generator's copy of the registers
    logic [7:0] term_c  = TERM_RESET;
    logic [7:0] delim_c = DELIM_RESET;
    logic [7:0] hdr_c   = HEADER_RESET;

    logic [7:0] frame_q[$];

    uart_text_command_decoder DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_command_code    (command_code),
        .o_run_on          (run_on),
        .o_speed_cmd       (speed_cmd),
        .o_value_saturated (value_saturated)
    );

    ucd_frame_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_rx_byte         (rx_byte),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_command_code    (command_code),
        .i_run_on          (run_on),
        .i_speed_cmd       (speed_cmd),
        .i_value_saturated (value_saturated),
        .o_mismatch_count  (mismatch_count),
        .o_pending_count   (pending_count),
        .o_result_count    (result_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Cycle count, watchdog
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // No idling on either side inside this window
    assign calm = (cyc >= CALM_FROM && cyc < CALM_TO);

    // Result side: random stalls, one long hold-off once results flow
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && result_count >= 12) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_byte(logic [7:0] b);
        while (!calm && $urandom_range(99) < 21) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
        frame_q.delete();
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_digit();
        if ($urandom_range(3) == 0) return CH_ONE;
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_space();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    // Header, delimiter and a number with random shape
    task automatic build_command();
        int pick;
        int n_int;
        int n_frac;
        int n_exp;
        frame_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : hdr_c);
        pick = $urandom_range(9);
        frame_q.push_back(pick < 5 ? CH_ONE : pick < 9 ? CH_TWO : 8'($urandom_range(255)));
        if ($urandom_range(9) == 0) frame_q.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(19) != 0) frame_q.push_back(delim_c);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) frame_q.push_back(rand_space());
        pick = $urandom_range(3);
        if (pick == 1) frame_q.push_back(CH_MINUS);
        else if (pick == 2) frame_q.push_back(CH_PLUS);
        pick = $urandom_range(19);
        n_int = pick < 14 ? $urandom_range(0, 3) : pick < 18 ? $urandom_range(4, 6)
                                                              : $urandom_range(9, 14);
        repeat (n_int) frame_q.push_back(rand_digit());
        if ($urandom_range(9) < 3) begin
            frame_q.push_back(CH_DOT);
            n_frac = ($urandom_range(19) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
            repeat (n_frac) frame_q.push_back(rand_digit());
        end
        if ($urandom_range(3) == 0) begin
            frame_q.push_back($urandom_range(1) ? CH_E_LO : CH_E_UP);
            pick = $urandom_range(3);
            if (pick == 1) frame_q.push_back(CH_MINUS);
            else if (pick == 2) frame_q.push_back(CH_PLUS);
            n_exp = ($urandom_range(9) == 0) ? 3 : $urandom_range(0, 2);
            repeat (n_exp) frame_q.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(4) == 0) frame_q.push_back(8'($urandom_range(255)));
        if ($urandom_range(19) == 0)
            frame_q.insert($urandom_range(frame_q.size()), CH_NUL);
        frame_q.push_back(term_c);
    endtask

    // Mostly well-formed commands, some noise and early-ended text
    task automatic build_random_frame();
        int pick;
        pick = $urandom_range(99);
        frame_q.delete();
        if (pick < 75) begin
            build_command();
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(255)));
            frame_q.push_back(term_c);
        end else begin
            frame_q.push_back(hdr_c);
            frame_q.push_back(CH_TWO);
            frame_q.push_back(CH_NUL);
            frame_q.push_back(delim_c);
            frame_q.push_back(rand_digit());
            frame_q.push_back(term_c);
        end
    endtask

    task automatic run_random(int n_beats);
        int stop_at;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            build_random_frame();
            send_frame();
        end
    endtask

    // Drain, then let the block go quiet before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_TERMINATOR: term_c  = data;
            REG_DELIMITER:  delim_c = data;
            REG_HEADER:     hdr_c   = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(logic [7:0] t, logic [7:0] d, logic [7:0] h);
        settle();
        write_reg(REG_TERMINATOR, t);
        write_reg(REG_DELIMITER, d);
        write_reg(REG_HEADER, h);
        write_reg(REG_SPARE, 8'($urandom_range(255)));
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_run++;
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        settings_run = 1;

        // Directed frames under the reset settings
        add_text("P1=1");
        frame_q.push_back(term_c);
        add_text("P2=-4e4");
        frame_q.push_back(term_c);
        add_text("Q2=1");
        frame_q.push_back(term_c);
        frame_q.push_back(8'hFF);
        frame_q.push_back(CH_NUL);
        add_text("=1");
        frame_q.push_back(term_c);
        send_frame();

        // Longest frame that fits, then one byte too many
        add_text("P2=7;");
        repeat (250) add_text("a");
        frame_q.push_back(term_c);
        send_frame();
        add_text("P2=7;");
        repeat (251) add_text("a");
        frame_q.push_back(term_c);
        send_frame();

        run_random(50);
        apply_setting(8'h0A, 8'h3A, 8'h53);
        run_random(50);
        apply_setting(8'h00, 8'hFF, 8'h00);
        run_random(50);
        apply_setting(8'hFF, 8'h00, 8'hFF);
        run_random(50);
        // terminator equal to delimiter
        apply_setting(8'h3D, 8'h3D, 8'h50);
        run_random(40);
        apply_setting(TERM_RESET, DELIM_RESET, HEADER_RESET);
        run_random(70);

        settle();
        $display("covered %0d byte beats and %0d results over %0d register settings",
                 beats_sent, result_count, settings_run);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
